>>> hw/rtl/lsre_pkg.sv
// Shared types and constants for the link-state route engine.
// No dependencies; imported by every RTL module of the block but lsre_chk.
package lsre_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int SEQ_WIDTH_DEF = 31;

  localparam int NODE_W     = 6;
  localparam int SEQ_IN_W   = 31;
  localparam int CNT_W      = 7;
  localparam int HOP_W      = 6;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic CFG_OWN_NODE   = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  // input kinds
  localparam logic KIND_LINK  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic in_load;
    logic ent_eval;
    logic walk_init;
    logic row_rd;
    logic row_eval;
    logic hop_wr;
    logic advance;
    logic q_eval;
    logic out_load;
  } lsre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic recompute;
    logic root_ok;
    logic u_hit;
    logic u_last;
    logic next_empty;
    logic pend_empty;
  } lsre_sts_t;

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_ENT_RD    = 11'b000_0000_0100,
    S_ENT_EV    = 11'b000_0000_1000,
    S_WALK_INIT = 11'b000_0001_0000,
    S_SCAN      = 11'b000_0010_0000,
    S_ROW_EV    = 11'b000_0100_0000,
    S_HOP_WR    = 11'b000_1000_0000,
    S_Q_RD      = 11'b001_0000_0000,
    S_Q_EV      = 11'b010_0000_0000,
    S_OUT       = 11'b100_0000_0000
  } lsre_state_t;

endpackage

>>> hw/rtl/link_state_route_engine_unit.sv
// Top level of the link-state route engine: controller plus datapath.
// Depends on lsre_pkg, lsre_ctrl and lsre_dp.
//
//  channel | handshake             | payload
//  cfg     | cfg_we                | cfg_index, cfg_data
//  in      | in_valid / in_stall   | kind, origin_node, neighbor_node, link_sequence,
//          |                       | last_entry, query_dest
//  out     | out_valid / out_stall | entry_changed, routes_recomputed, route_found,
//          |                       | next_hop, hop_count
//
// A query or a link entry is captured, read from the tables, evaluated into a
// staged result and then loaded into the result registers. A recompute adds a
// breadth-first walk: each level scans all active nodes one a cycle, pausing at
// each frontier node to read its row and write a hop entry per new node found.
// After reset a clearing pass runs over the adjacency rows, with in_stall high.
// A stalled result holds while the next item is taken.
module link_state_route_engine_unit import lsre_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [NODE_W-1:0]     origin_node,
  input  logic [NODE_W-1:0]     neighbor_node,
  input  logic [SEQ_IN_W-1:0]   link_sequence,
  input  logic                  last_entry,
  input  logic [NODE_W-1:0]     query_dest,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  entry_changed,
  output logic                  routes_recomputed,
  output logic                  route_found,
  output logic [NODE_W-1:0]     next_hop,
  output logic [HOP_W-1:0]      hop_count
);

  lsre_cmd_t cmd;
  lsre_sts_t sts;

  lsre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lsre_dp #(
    .MAX_NODES (MAX_NODES),
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .origin_node       (origin_node),
    .neighbor_node     (neighbor_node),
    .link_sequence     (link_sequence),
    .last_entry        (last_entry),
    .query_dest        (query_dest),
    .cmd               (cmd),
    .sts               (sts),
    .entry_changed     (entry_changed),
    .routes_recomputed (routes_recomputed),
    .route_found       (route_found),
    .next_hop          (next_hop),
    .hop_count         (hop_count)
  );

endmodule

>>> hw/rtl/lsre_ctrl.sv
// Controller state machine of the link-state route engine.
// Depends on lsre_pkg; drives commands into lsre_dp and reads its status.
module lsre_ctrl import lsre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      kind,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output lsre_cmd_t cmd,
  input  lsre_sts_t sts
);

  lsre_state_t state, state_next;
  logic        out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = (kind == KIND_QUERY) ? S_Q_RD : S_ENT_RD;
        end
      end
      S_ENT_RD: state_next = S_ENT_EV;
      S_ENT_EV: begin
        cmd.ent_eval = 1'b1;
        state_next   = sts.recompute ? S_WALK_INIT : S_OUT;
      end
      S_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_next    = sts.root_ok ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        if (sts.u_hit) begin
          cmd.row_rd = 1'b1;
          state_next = S_ROW_EV;
        end else begin
          cmd.advance = 1'b1;
          if (sts.u_last && sts.next_empty) state_next = S_OUT;
        end
      end
      S_ROW_EV: begin
        cmd.row_eval = 1'b1;
        state_next   = S_HOP_WR;
      end
      S_HOP_WR: begin
        if (!sts.pend_empty) begin
          cmd.hop_wr = 1'b1;
        end else begin
          cmd.advance = 1'b1;
          state_next  = (sts.u_last && sts.next_empty) ? S_OUT : S_SCAN;
        end
      end
      S_Q_RD: state_next = S_Q_EV;
      S_Q_EV: begin
        cmd.q_eval = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // output valid: set on load, dropped on transfer
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hw/rtl/lsre_dp.sv
// Datapath of the link-state route engine: config, link store, walk, route tables.
// Depends on lsre_pkg; commanded by lsre_ctrl.
module lsre_dp import lsre_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [NODE_W-1:0]     origin_node,
  input  logic [NODE_W-1:0]     neighbor_node,
  input  logic [SEQ_IN_W-1:0]   link_sequence,
  input  logic                  last_entry,
  input  logic [NODE_W-1:0]     query_dest,
  input  lsre_cmd_t             cmd,
  output lsre_sts_t             sts,
  output logic                  entry_changed,
  output logic                  routes_recomputed,
  output logic                  route_found,
  output logic [NODE_W-1:0]     next_hop,
  output logic [HOP_W-1:0]      hop_count
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CW     = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;
  localparam int SLOT_W = 2 * NW;
  localparam int SEQ_D  = 2 ** SLOT_W;

  localparam logic [CW-1:0] MAX_W = CW'(MAX_NODES);
  localparam logic [MAX_NODES-1:0] ONE = MAX_NODES'(1);

  // configuration registers
  logic [NODE_W-1:0] own_node;
  logic [CNT_W-1:0]  node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node   <= '0;
      node_count <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_NODE:   own_node   <= cfg_data[NODE_W-1:0];
        CFG_NODE_COUNT: node_count <= cfg_data[CNT_W-1:0];
        default:        ;
      endcase
    end
  end

  logic [CW-1:0] act_n;
  logic [CW-1:0] own_w;
  logic [MAX_NODES-1:0] act_mask;

  assign act_n = (CW'(node_count) > MAX_W) ? MAX_W : CW'(node_count);
  assign own_w = CW'(own_node);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) act_mask[i] = (CW'(i) < act_n);
  end

  // captured input item
  logic [NODE_W-1:0]    cap_org, cap_nbr, cap_dest;
  logic [SEQ_WIDTH-1:0] cap_seq;
  logic                 cap_last;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cap_org  <= origin_node;
      cap_nbr  <= neighbor_node;
      cap_seq  <= SEQ_WIDTH'(link_sequence);
      cap_last <= last_entry;
      cap_dest <= query_dest;
    end
  end

  logic [NW-1:0]     org_idx, nbr_idx, dest_idx;
  logic [SLOT_W-1:0] slot;
  assign org_idx  = NW'(cap_org);
  assign nbr_idx  = NW'(cap_nbr);
  assign dest_idx = NW'(cap_dest);
  assign slot     = {org_idx, nbr_idx};

  // walk registers
  logic [NW-1:0]        u;
  logic [CW-1:0]        level;
  logic [MAX_NODES-1:0] frontier, next_front, visited, rvalid, pend;
  logic [NW-1:0]        fh_base;
  logic                 root_u;
  logic [NW-1:0]        clr_cnt;
  logic                 pkt_changed;

  // memories
  logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] adjt_mem [MAX_NODES];
  logic [SEQ_WIDTH-1:0] seq_mem  [SEQ_D];
  logic [NW-1:0]        fh_mem   [MAX_NODES];
  logic [HOP_W-1:0]     hops_mem [MAX_NODES];

  logic [MAX_NODES-1:0] adj_rd, adjt_rd;
  logic [SEQ_WIDTH-1:0] seq_rd;
  logic [NW-1:0]        fh_rd;
  logic [HOP_W-1:0]     hops_rd;

  logic [NW-1:0] adj_raddr, adjt_raddr, fh_raddr;
  assign adj_raddr  = cmd.row_rd ? u : org_idx;
  assign adjt_raddr = cmd.row_rd ? u : nbr_idx;
  assign fh_raddr   = cmd.row_rd ? u : dest_idx;

  // link entry evaluation
  logic in_range, present, chg;
  assign in_range = (CW'(cap_org) < MAX_W) && (CW'(cap_nbr) < MAX_W);
  assign present  = adj_rd[nbr_idx];
  assign chg      = in_range && (!present || (cap_seq > seq_rd));

  logic                 adj_we;
  logic [NW-1:0]        adj_waddr, adjt_waddr;
  logic [MAX_NODES-1:0] adj_wdata, adjt_wdata;
  assign adj_we     = cmd.clr_wr || (cmd.ent_eval && chg);
  assign adj_waddr  = cmd.clr_wr ? clr_cnt : org_idx;
  assign adjt_waddr = cmd.clr_wr ? clr_cnt : nbr_idx;
  assign adj_wdata  = cmd.clr_wr ? '0 : (adj_rd | (ONE << nbr_idx));
  assign adjt_wdata = cmd.clr_wr ? '0 : (adjt_rd | (ONE << org_idx));

  // lowest pending node of the current row
  logic [NW-1:0] low_v;
  always_comb begin
    low_v = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (pend[i]) low_v = NW'(i);
    end
  end

  logic [NW-1:0]    fh_wdata;
  logic [HOP_W-1:0] hops_wdata;
  assign fh_wdata   = root_u ? low_v : fh_base;
  assign hops_wdata = HOP_W'(level + CW'(1));

  always_ff @(posedge clk) begin
    adj_rd  <= adj_mem[adj_raddr];
    adjt_rd <= adjt_mem[adjt_raddr];
    seq_rd  <= seq_mem[slot];
    fh_rd   <= fh_mem[fh_raddr];
    hops_rd <= hops_mem[fh_raddr];
    if (adj_we) begin
      adj_mem[adj_waddr]   <= adj_wdata;
      adjt_mem[adjt_waddr] <= adjt_wdata;
    end
    if (cmd.ent_eval && chg) seq_mem[slot] <= cap_seq;
    if (cmd.hop_wr) begin
      fh_mem[low_v]   <= fh_wdata;
      hops_mem[low_v] <= hops_wdata;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + NW'(1);
  end

  // update packet change flag
  always_ff @(posedge clk) begin
    if (rst) pkt_changed <= 1'b0;
    else if (cmd.ent_eval) pkt_changed <= cap_last ? 1'b0 : (pkt_changed || chg);
  end

  // breadth-first walk state
  logic [MAX_NODES-1:0] row_new;
  assign row_new = (adj_rd | adjt_rd) & ~visited & act_mask & ~(ONE << u);

  logic root_ok, u_last;
  assign root_ok = own_w < act_n;
  assign u_last  = (CW'(u) == act_n - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      u          <= '0;
      level      <= '0;
      frontier   <= '0;
      next_front <= '0;
      visited    <= '0;
      rvalid     <= '0;
      pend       <= '0;
    end else begin
      if (cmd.walk_init) begin
        u          <= '0;
        level      <= '0;
        next_front <= '0;
        rvalid     <= '0;
        pend       <= '0;
        frontier   <= root_ok ? (ONE << NW'(own_node)) : '0;
        visited    <= root_ok ? (ONE << NW'(own_node)) : '0;
      end
      if (cmd.row_eval) begin
        pend       <= row_new;
        visited    <= visited | row_new;
        next_front <= next_front | row_new;
        rvalid     <= rvalid | row_new;
      end
      if (cmd.hop_wr) pend <= pend & ~(ONE << low_v);
      if (cmd.advance) begin
        if (u_last) begin
          frontier   <= next_front;
          next_front <= '0;
          level      <= level + CW'(1);
          u          <= '0;
        end else begin
          u <= u + NW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_eval) begin
      fh_base <= fh_rd;
      root_u  <= (CW'(u) == own_w);
    end
  end

  // staged result and output registers
  logic              res_chg, res_recomp, res_found;
  logic [NODE_W-1:0] res_hop;
  logic [HOP_W-1:0]  res_hops;
  logic              dest_ok;

  assign dest_ok = (CW'(cap_dest) < act_n) && (cap_dest != own_node) && rvalid[dest_idx];

  always_ff @(posedge clk) begin
    if (cmd.ent_eval) begin
      res_chg    <= chg;
      res_recomp <= cap_last && (pkt_changed || chg);
      res_found  <= 1'b0;
      res_hop    <= '0;
      res_hops   <= '0;
    end
    if (cmd.q_eval) begin
      res_chg    <= 1'b0;
      res_recomp <= 1'b0;
      res_found  <= dest_ok;
      res_hop    <= dest_ok ? NODE_W'(fh_rd) : '0;
      res_hops   <= dest_ok ? hops_rd : '0;
    end
    if (cmd.out_load) begin
      entry_changed     <= res_chg;
      routes_recomputed <= res_recomp;
      route_found       <= res_found;
      next_hop          <= res_hop;
      hop_count         <= res_hops;
    end
  end

  // status to controller
  assign sts.clr_last   = (CW'(clr_cnt) == MAX_W - CW'(1));
  assign sts.recompute  = cap_last && (pkt_changed || chg);
  assign sts.root_ok    = root_ok;
  assign sts.u_hit      = frontier[u];
  assign sts.u_last     = u_last;
  assign sts.next_empty = (next_front == '0);
  assign sts.pend_empty = (pend == '0);

endmodule

>>> hw/rtl/lsre_chk.sv
// Port-level checker for the link-state route engine, bound to the top level.
// No package dependency; sees only the top-level ports.
module lsre_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       entry_changed,
  input logic       routes_recomputed,
  input logic       route_found,
  input logic [5:0] next_hop,
  input logic [5:0] hop_count
);

  // a stalled result holds (routes_recomputed is not checked)
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_hop) && $stable(hop_count)
      && $stable(route_found) && $stable(entry_changed))
    else $error("result changed while stalled");

  // found-route results never carry entry flags
  a_query_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && route_found |-> !entry_changed && !routes_recomputed)
    else $error("query result with entry flags");

  // no route means zero hop fields
  a_no_route_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !route_found |-> next_hop == 6'd0 && hop_count == 6'd0)
    else $error("nonzero hop fields without a route");

  // reset empties the output and starts the clearing pass
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("output or input open right after reset");

endmodule

bind link_state_route_engine_unit lsre_chk u_lsre_chk (.*);
